### sv/swa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_pkg
// Shared types and constants for the stable window average block.
// ----------------------------------------------------------------------------
package swa_pkg;

	localparam int WINDOW_LEN  = 25;
	localparam int SAMPLE_W    = 16;
	localparam int LIMIT_W     = 16;
	localparam int AVG_W       = 13;
	localparam int CNT_W       = $clog2(WINDOW_LEN);

	localparam logic [SAMPLE_W-1:0] MIN_SENTINEL = SAMPLE_W'(10000);
	localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(40);

	// x / 10 for 16-bit x: (x * 0xCCCD) >> 19
	localparam int DIV10_W     = 16;
	localparam logic [DIV10_W-1:0] DIV10_MUL = DIV10_W'(52429);
	localparam int DIV10_SHIFT = 19;
	localparam int TENTH_MAX   = 6553;

	// sum of tenths and the rounded division by the window length
	localparam int SUM_MAX     = WINDOW_LEN * TENTH_MAX;
	localparam int SUM_W       = $clog2(SUM_MAX + 1);
	localparam int ROUND_ADD   = WINDOW_LEN - WINDOW_LEN / 2;
	localparam int NUM_W       = $clog2(SUM_MAX + ROUND_ADD + 1);
	localparam int DIV_SHIFT   = NUM_W + 6;
	localparam longint RECIP   = ((64'd1 << DIV_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
	localparam int RECIP_W     = $clog2(RECIP + 1);
	localparam int PROD_W      = NUM_W + RECIP_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FLUSH,
		S_DIVIDE,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic clear;
		logic scan;
	} acc_ctrl_t;

endpackage

### sv/swa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_cell
// One window entry; loads its neighbor's value when the chain advances.
// ----------------------------------------------------------------------------
module swa_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [swa_pkg::SAMPLE_W-1:0] d,
	output logic [swa_pkg::SAMPLE_W-1:0] q
);
	import swa_pkg::*;

	logic [SAMPLE_W-1:0] val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (en) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule

### sv/swa_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_accum
// Tracks max, min and the sum of tenths over the entries leaving the chain head.
// ----------------------------------------------------------------------------
module swa_accum (
	input  logic                         clk,
	input  logic                         arst_n,
	input  swa_pkg::acc_ctrl_t           ctrl,
	input  logic [swa_pkg::SAMPLE_W-1:0] head,
	output logic [swa_pkg::SAMPLE_W-1:0] hi,
	output logic [swa_pkg::SAMPLE_W-1:0] lo,
	output logic [swa_pkg::SUM_W-1:0]    sum
);
	import swa_pkg::*;

	logic [SAMPLE_W-1:0]         hi_q;
	logic [SAMPLE_W-1:0]         lo_q;
	logic [SUM_W-1:0]            sum_q;
	logic [SAMPLE_W+DIV10_W-1:0] prod;
	logic [AVG_W-1:0]            tenth_s1;
	logic                        tenth_vld_s1;

	assign prod = head * DIV10_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tenth_vld_s1 <= 1'b0;
		end else begin
			tenth_vld_s1 <= ctrl.scan;
		end
	end

	always_ff @(posedge clk) begin
		tenth_s1 <= prod[DIV10_SHIFT +: AVG_W];
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			hi_q  <= '0;
			lo_q  <= MIN_SENTINEL;
			sum_q <= '0;
		end else begin
			if (ctrl.scan) begin
				if (head > hi_q) begin
					hi_q <= head;
				end
				if (head < lo_q) begin
					lo_q <= head;
				end
			end
			if (tenth_vld_s1) begin
				sum_q <= sum_q + SUM_W'(tenth_s1);
			end
		end
	end

	assign hi  = hi_q;
	assign lo  = lo_q;
	assign sum = sum_q;

endmodule

### sv/stable_window_average_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_window_average_top
// Range-gated moving average over a window of the latest sensor samples.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// input     in         in_valid / in_stall    sample[15:0]
// output    out        out_valid / out_stall  average[12:0], stable
// config    in         cfg_we                 cfg_data[15:0]
//
// An item is shifted in with its sample, then the cell chain rotates once fully
// past the accumulator, then the block steps through flush, divide and finish.
// The single accumulator on the chain head lets only one item be in work at a time.
// Reset clears the window to zeros and the limit to 40.
// A stalled output holds its item; a new item is taken while it waits.
// ----------------------------------------------------------------------------
module stable_window_average_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [swa_pkg::SAMPLE_W-1:0] sample,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [swa_pkg::AVG_W-1:0]    average,
	output logic                         stable,
	input  logic                         cfg_we,
	input  logic [swa_pkg::LIMIT_W-1:0]  cfg_data
);
	import swa_pkg::*;

	state_t              state_q;
	state_t              state_d;
	logic [CNT_W-1:0]    cnt_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic                accept;
	logic                chain_en;
	logic                load_out;
	logic [SAMPLE_W-1:0] tail_d;
	logic [SAMPLE_W-1:0] cell_q [WINDOW_LEN];
	logic [SAMPLE_W-1:0] hi;
	logic [SAMPLE_W-1:0] lo;
	logic [SUM_W-1:0]    sum;
	acc_ctrl_t           acc_ctrl;
	logic [PROD_W-1:0]   quot_prod_q;
	logic                stable_q;
	logic                out_valid_q;
	logic [AVG_W-1:0]    average_q;
	logic                out_stable_q;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign chain_en = accept || (state_q == S_SCAN);
	assign tail_d   = accept ? sample : cell_q[0];

	// cell chain: each cell takes its upper neighbor, the tail takes sample or head
	for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
		if (i == WINDOW_LEN - 1) begin : g_tail
			swa_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (chain_en),
				.d      (tail_d),
				.q      (cell_q[i])
			);
		end else begin : g_body
			swa_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (chain_en),
				.d      (cell_q[i+1]),
				.q      (cell_q[i])
			);
		end
	end

	assign acc_ctrl.clear = accept;
	assign acc_ctrl.scan  = (state_q == S_SCAN);

	swa_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (acc_ctrl),
		.head   (cell_q[0]),
		.hi     (hi),
		.lo     (lo),
		.sum    (sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SCAN) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (cnt_q == CNT_W'(WINDOW_LEN - 1)) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				state_d = S_DIVIDE;
			end
			S_DIVIDE: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// rounded quotient by reciprocal multiply: (sum + L - L/2) / L
	always_ff @(posedge clk) begin
		if (state_q == S_DIVIDE) begin
			quot_prod_q <= PROD_W'(NUM_W'(sum) + NUM_W'(ROUND_ADD)) * PROD_W'(RECIP);
			stable_q    <= (hi - lo) < limit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			average_q    <= stable_q ? quot_prod_q[DIV_SHIFT +: AVG_W] : '0;
			out_stable_q <= stable_q;
		end
	end

	assign out_valid = out_valid_q;
	assign average   = average_q;
	assign stable    = out_stable_q;

	a_zero_when_unstable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !stable |-> average == '0)
		else $error("unstable item carries nonzero average");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_SCAN && cnt_q == '0)
		else $error("accepted item did not start a scan");

	a_range_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIVIDE |-> hi >= lo)
		else $error("window max below min after scan");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(average_q))
		else $error("stalled output item was dropped or changed");

endmodule
